[rtl/udp_port_allocator_unit_defines.svh]
// Assertion macros for the udp_port_allocator_unit checker.
// Expects aclk and aresetn to be visible where the macros are used.
`ifndef UDP_PORT_ALLOCATOR_UNIT_DEFINES_SVH
`define UDP_PORT_ALLOCATOR_UNIT_DEFINES_SVH

// Checked only outside reset.
`define UPA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked in every cycle, reset included.
`define UPA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[rtl/upa_pkg.sv]
// Shared types and constants of the UDP port allocator.
// No dependencies.
package upa_pkg;

    localparam int PORT_W     = 16;
    localparam int FUNC_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_W      = 16;
    localparam int CFG_ADDR_W = 1;

    localparam int unsigned EPH_LOW_RST  = 32768;
    localparam int unsigned EPH_HIGH_RST = 60999;
    localparam int unsigned NEXT_RST     = 32768;

    localparam logic [FUNC_W-1:0] FN_BIND    = 2'd0;
    localparam logic [FUNC_W-1:0] FN_ALLOC   = 2'd1;
    localparam logic [FUNC_W-1:0] FN_RELEASE = 2'd2;

    localparam logic [STATUS_W-1:0] STS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STS_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] STS_BUSY    = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] CFG_EPH_LOW  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_EPH_HIGH = 1'b1;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_CLEAR,
        WR_SET_ITEM,
        WR_CLR_ITEM,
        WR_SET_FOUND
    } wr_op_t;

    typedef enum logic [1:0] {
        GR_NONE,
        GR_ITEM,
        GR_FOUND
    } grant_sel_t;

    typedef struct packed {
        logic                load;
        logic                scan_start;
        logic                scan_run;
        wr_op_t              wr_op;
        logic                res_set;
        logic [STATUS_W-1:0] res_status;
        grant_sel_t          res_grant;
        logic                res_push;
    } upa_cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              port_zero;
        logic              range_bad;
        logic              item_busy;
        logic              scan_hit;
        logic              scan_miss;
        logic              clear_last;
        logic              out_free;
    } upa_sts_t;

endpackage

[rtl/upa_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module upa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/upa_ctrl.sv]
// Sequencer of the UDP port allocator: clear pass, decode, lookup, scan, result.
// Depends on upa_pkg.
module upa_ctrl import upa_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  upa_sts_t sts,
    output upa_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_WAIT,
        S_SCAN,
        S_RESULT
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.wr_op      = WR_NONE;
        cmd.res_status = STS_OK;
        cmd.res_grant  = GR_NONE;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.wr_op = WR_CLEAR;
                if (sts.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (sts.func)
                    FN_BIND: begin
                        if (sts.port_zero) begin
                            cmd.res_set    = 1'b1;
                            cmd.res_status = STS_INVALID;
                            state_next     = S_RESULT;
                        end else begin
                            state_next = S_WAIT;
                        end
                    end
                    FN_ALLOC: begin
                        if (sts.range_bad) begin
                            cmd.res_set    = 1'b1;
                            cmd.res_status = STS_BUSY;
                            state_next     = S_RESULT;
                        end else begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end
                    FN_RELEASE: begin
                        if (sts.port_zero) begin
                            cmd.res_set = 1'b1;
                            state_next  = S_RESULT;
                        end else begin
                            state_next = S_WAIT;
                        end
                    end
                    default: begin
                        cmd.res_set    = 1'b1;
                        cmd.res_status = STS_INVALID;
                        state_next     = S_RESULT;
                    end
                endcase
            end
            S_WAIT: begin
                cmd.res_set = 1'b1;
                state_next  = S_RESULT;
                if (sts.func == FN_BIND) begin
                    if (sts.item_busy) begin
                        cmd.res_status = STS_BUSY;
                    end else begin
                        cmd.wr_op     = WR_SET_ITEM;
                        cmd.res_grant = GR_ITEM;
                    end
                end else begin
                    cmd.wr_op = WR_CLR_ITEM;
                end
            end
            S_SCAN: begin
                cmd.scan_run = 1'b1;
                if (sts.scan_hit) begin
                    cmd.wr_op     = WR_SET_FOUND;
                    cmd.res_set   = 1'b1;
                    cmd.res_grant = GR_FOUND;
                    state_next    = S_RESULT;
                end else if (sts.scan_miss) begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = STS_BUSY;
                    state_next     = S_RESULT;
                end
            end
            S_RESULT: begin
                if (sts.out_free) begin
                    cmd.res_push = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/upa_datapath.sv]
// Datapath of the UDP port allocator: range registers, in-use map, scan
// pipeline, next-fit pointer and result register. Depends on upa_pkg, upa_ram.
module upa_datapath import upa_pkg::*; #(
    parameter int PORT_BITS     = 16,
    parameter int MAP_WORD_BITS = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic [PORT_W-1:0]     s_tdata,
    input  logic [FUNC_W-1:0]     s_tuser,
    input  upa_cmd_t              cmd,
    output upa_sts_t              sts,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [PORT_W-1:0]     m_tdata,
    output logic [STATUS_W-1:0]   m_tuser
);

    localparam int LG_W    = $clog2(MAP_WORD_BITS);
    localparam int WORD_AW = PORT_BITS - LG_W;
    localparam int DEPTH   = 1 << WORD_AW;

    typedef logic [PORT_BITS-1:0]     port_t;
    typedef logic [WORD_AW-1:0]       waddr_t;
    typedef logic [LG_W-1:0]          boff_t;
    typedef logic [MAP_WORD_BITS-1:0] mword_t;

    function automatic waddr_t word_of(port_t p);
        return p[PORT_BITS-1:LG_W];
    endfunction

    function automatic boff_t bit_of(port_t p);
        return p[LG_W-1:0];
    endfunction

    port_t               lo_reg, hi_reg, next_reg;
    logic [FUNC_W-1:0]   func_reg;
    port_t               port_reg, p_reg;
    waddr_t              iss_word_reg, eval_word_reg, clr_cnt_reg;
    logic                iss_seg_reg, iss_active_reg;
    logic                eval_seg_reg, eval_valid_reg, eval_last_reg;
    logic [STATUS_W-1:0] res_status_reg, m_status_reg;
    port_t               res_grant_reg, m_grant_reg;
    logic                m_valid_reg;

    port_t  start_p, p_m1, ev_lo, ev_hi, found_port, grant_next;
    waddr_t iss_end_word, raddr, waddr;
    logic   b_empty, ram_we, hit_any;
    mword_t rdata, wdata, mask_lo, mask_hi, mask_z, free_bits, onehot, item_mask;
    boff_t  found_idx;

    assign start_p      = (next_reg < lo_reg || next_reg > hi_reg) ? lo_reg : next_reg;
    assign p_m1         = p_reg - 1'b1;
    assign b_empty      = (p_reg == lo_reg);
    assign iss_end_word = iss_seg_reg ? word_of(p_m1) : word_of(hi_reg);

    // segment 0 covers [p, hi], segment 1 wraps to [lo, p - 1]
    assign ev_lo = eval_seg_reg ? lo_reg : p_reg;
    assign ev_hi = eval_seg_reg ? p_m1 : hi_reg;

    assign mask_lo = (eval_word_reg == word_of(ev_lo))
                   ? ({MAP_WORD_BITS{1'b1}} << bit_of(ev_lo)) : {MAP_WORD_BITS{1'b1}};
    assign mask_hi = (eval_word_reg == word_of(ev_hi))
                   ? ({MAP_WORD_BITS{1'b1}} >> (boff_t'(MAP_WORD_BITS - 1) - bit_of(ev_hi)))
                   : {MAP_WORD_BITS{1'b1}};
    // port zero is never granted
    assign mask_z  = (eval_word_reg == '0) ? ~mword_t'(1) : {MAP_WORD_BITS{1'b1}};

    assign free_bits = ~rdata & mask_lo & mask_hi & mask_z;
    assign hit_any   = |free_bits;
    assign onehot    = free_bits & (~free_bits + 1'b1);

    always_comb begin
        found_idx = '0;
        for (int i = 0; i < MAP_WORD_BITS; i++) begin
            if (onehot[i]) begin
                found_idx = found_idx | boff_t'(i);
            end
        end
    end

    assign found_port = {eval_word_reg, found_idx};
    assign item_mask  = mword_t'(1) << bit_of(port_reg);
    assign raddr      = cmd.scan_run ? iss_word_reg : word_of(port_reg);

    always_comb begin
        unique case (cmd.wr_op)
            WR_CLEAR: begin
                ram_we = 1'b1;
                waddr  = clr_cnt_reg;
                wdata  = '0;
            end
            WR_SET_ITEM: begin
                ram_we = 1'b1;
                waddr  = word_of(port_reg);
                wdata  = rdata | item_mask;
            end
            WR_CLR_ITEM: begin
                ram_we = 1'b1;
                waddr  = word_of(port_reg);
                wdata  = rdata & ~item_mask;
            end
            WR_SET_FOUND: begin
                ram_we = 1'b1;
                waddr  = eval_word_reg;
                wdata  = rdata | onehot;
            end
            default: begin
                ram_we = 1'b0;
                waddr  = word_of(port_reg);
                wdata  = rdata;
            end
        endcase
    end

    always_comb begin
        unique case (cmd.res_grant)
            GR_ITEM:  grant_next = port_reg;
            GR_FOUND: grant_next = found_port;
            default:  grant_next = '0;
        endcase
    end

    upa_ram #(
        .WIDTH (MAP_WORD_BITS),
        .DEPTH (DEPTH)
    ) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lo_reg         <= port_t'(EPH_LOW_RST);
            hi_reg         <= port_t'(EPH_HIGH_RST);
            next_reg       <= port_t'(NEXT_RST);
            clr_cnt_reg    <= '0;
            iss_active_reg <= 1'b0;
            eval_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en && cfg_addr == CFG_EPH_LOW) begin
                lo_reg <= cfg_wdata[PORT_BITS-1:0];
            end
            if (cfg_wr_en && cfg_addr == CFG_EPH_HIGH) begin
                hi_reg <= cfg_wdata[PORT_BITS-1:0];
            end
            if (cmd.wr_op == WR_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.wr_op == WR_SET_FOUND) begin
                next_reg <= found_port + 1'b1;
            end
            if (cmd.scan_start) begin
                iss_active_reg <= 1'b1;
                eval_valid_reg <= 1'b0;
            end else if (cmd.scan_run) begin
                eval_valid_reg <= iss_active_reg;
                if (iss_word_reg == iss_end_word && (iss_seg_reg || b_empty)) begin
                    iss_active_reg <= 1'b0;
                end
            end
            if (cmd.res_push) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg <= s_tuser;
            port_reg <= s_tdata[PORT_BITS-1:0];
        end
        if (cmd.scan_start) begin
            p_reg        <= start_p;
            iss_word_reg <= word_of(start_p);
            iss_seg_reg  <= 1'b0;
        end else if (cmd.scan_run) begin
            eval_word_reg <= iss_word_reg;
            eval_seg_reg  <= iss_seg_reg;
            eval_last_reg <= (iss_seg_reg || b_empty) && (iss_word_reg == iss_end_word);
            if (iss_word_reg == iss_end_word) begin
                if (!iss_seg_reg && !b_empty) begin
                    iss_seg_reg  <= 1'b1;
                    iss_word_reg <= word_of(lo_reg);
                end
            end else begin
                iss_word_reg <= iss_word_reg + 1'b1;
            end
        end
        if (cmd.res_set) begin
            res_status_reg <= cmd.res_status;
            res_grant_reg  <= grant_next;
        end
        if (cmd.res_push) begin
            m_status_reg <= res_status_reg;
            m_grant_reg  <= res_grant_reg;
        end
    end

    assign sts.func       = func_reg;
    assign sts.port_zero  = (port_reg == '0);
    assign sts.range_bad  = (lo_reg > hi_reg);
    assign sts.item_busy  = |(rdata & item_mask);
    assign sts.scan_hit   = eval_valid_reg && hit_any;
    assign sts.scan_miss  = eval_valid_reg && eval_last_reg && !hit_any;
    assign sts.clear_last = (clr_cnt_reg == {WORD_AW{1'b1}});
    assign sts.out_free   = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = PORT_W'(m_grant_reg);

endmodule

[rtl/udp_port_allocator_unit.sv]
// Top level of the UDP port allocator: bind, next-fit allocate, release.
// Depends on upa_pkg, upa_ctrl, upa_datapath (and upa_ram below it).
//
//  channel  | handshake          | tuser          | tdata
//  ---------+--------------------+----------------+--------------------
//  s_       | s_tvalid/s_tready  | func [1:0]     | port_number [15:0]
//  m_       | m_tvalid/m_tready  | status [1:0]   | granted_port [15:0]
//  cfg_     | cfg_wr_en          | -              | cfg_addr, cfg_wdata
//
// Bind and release: decode, map word lookup and update, then result; decode settles
//   the item itself for port zero or an unused code (and, on allocate, low above high).
// Allocate: decode, scan, then result; the scan reads N map words, one per cycle
//   from the in-use RAM read port; N is at most 443 for the reset range.
// After reset a clearing pass writes every map word, with s_tready low. Items are
//   taken one at a time: the next only once the last is pushed to its output register.
// A result waiting on m_tready does not block the next transfer in; that item
//   holds at its result until the output register frees. MAP_WORD_BITS: power of 2.
module udp_port_allocator_unit import upa_pkg::*; #(
    parameter int PORT_BITS     = 16,
    parameter int MAP_WORD_BITS = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PORT_W-1:0]     s_tdata,   // [15:0] port_number
    input  logic [FUNC_W-1:0]     s_tuser,   // [1:0] func
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [PORT_W-1:0]     m_tdata,   // [15:0] granted_port
    output logic [STATUS_W-1:0]   m_tuser    // [1:0] status
);

    upa_cmd_t cmd;
    upa_sts_t sts;

    upa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    upa_datapath #(
        .PORT_BITS     (PORT_BITS),
        .MAP_WORD_BITS (MAP_WORD_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

[rtl/upa_checker.sv]
// Port-level assertions for udp_port_allocator_unit, bound to the top level.
// Depends on upa_pkg and udp_port_allocator_unit_defines.svh.
`include "udp_port_allocator_unit_defines.svh"

module upa_checker import upa_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [PORT_W-1:0]   m_tdata,
    input logic [STATUS_W-1:0] m_tuser
);

    `UPA_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !m_tvalid, "result valid after reset")
    `UPA_ASSERT(a_one_at_a_time, s_tvalid && s_tready |=> !s_tready, "second transfer taken")
    `UPA_ASSERT(a_fail_no_grant, m_tvalid && m_tuser != STS_OK |-> m_tdata == '0, "grant on fail")
    `UPA_ASSERT(a_status_code, m_tvalid |-> m_tuser <= STS_BUSY, "undefined status code")
    `UPA_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind udp_port_allocator_unit upa_checker u_upa_checker (.*);
